/* src/macl_pkg.sv */
// Shared constants, types and controller encodings for the moving average lockout unit.
package macl_pkg;

   // Window geometry
   localparam int WINDOW_LEN = 50;
   localparam int ADDR_W     = $clog2(WINDOW_LEN);

   // Field widths
   localparam int CODE_W = 12;
   localparam int MV_W   = 12;
   localparam int THR_W  = 12;
   localparam int EST_W  = 15;

   // Millivolt scaling: mv = MV_TOP - floor((CODE_MAX - code) * MV_SPAN / CODE_MAX)
   localparam int CODE_MAX  = 4095;
   localparam int MV_TOP    = 3300;
   localparam int MV_SPAN   = 3020;
   localparam int SCALE_W   = 24;

   // Running sum and reciprocal for the window average
   localparam int SUM_W       = $clog2(WINDOW_LEN * MV_TOP + 1);
   localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW_LEN);
   localparam longint AVG_MULT = ((64'd1 << AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int AVG_MULT_W  = $clog2(AVG_MULT + 1);
   localparam int AVG_PROD_W  = SUM_W + AVG_MULT_W;

   // Current estimate: (EST_BASE - EST_SLOPE * avg) / 1000, toward zero
   localparam int EST_BASE    = 9800000;
   localparam int EST_SLOPE   = 3179;
   localparam int PROD_W      = 24;
   localparam int DIV_PRE     = 3;     // divide by 8 first, then by 125
   localparam int DIV_IN_W    = PROD_W - DIV_PRE;
   localparam int DIV_SHIFT   = DIV_IN_W + 7;
   localparam longint DIV_MULT = ((64'd1 << DIV_SHIFT) + 124) / 125;
   localparam int DIV_MULT_W  = $clog2(DIV_MULT + 1);
   localparam int DIV_PROD_W  = DIV_IN_W + DIV_MULT_W;
   localparam int QUOT_W      = 14;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_LOCK_ON   = 2'd1,
      CSR_LOCK_OFF  = 2'd2
   } csr_idx_type;

   localparam logic [THR_W-1:0]        THRESHOLD_RST = 12'd10;
   localparam logic signed [EST_W-1:0] LOCK_ON_RST   = 15'sd500;
   localparam logic signed [EST_W-1:0] LOCK_OFF_RST  = 15'sd100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_ACC,
      ST_AVG,
      ST_CMP,
      ST_MAG,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic acc;
      logic avg;
      logic cmp;
      logic mag;
      logic div;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic window_full;
   } dp_status_type;

endpackage

/* src/moving_average_change_lockout_unit.sv */
// Top level of the moving average change lockout unit: controller plus datapath.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_stall   | req_adc_code
//   rsp     | out       | rsp_valid/rsp_stall   | rsp_ready_res, rsp_average_mv, rsp_report,
//           |           |                       | rsp_current_est, rsp_lockout
//   csr     | in        | csr_we                | csr_index, csr_wdata
//
// One transaction at a time. While the window fills, a sample skips the average and
// estimate steps; once it is full, the scale, average and estimate multiplies each feed
// a register, and the ring read-modify-write spans the capture and accumulate steps.
// A finished result waits in the output register while the next sample is accepted.
// Reset is synchronous; it empties the window, clears the sum and lockout, restores CSRs.
// A stalled result holds the last step until the output register frees.
module moving_average_change_lockout_unit
   import macl_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CODE_W-1:0]       req_adc_code,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ready_res,
   output logic [MV_W-1:0]         rsp_average_mv,
   output logic                    rsp_report,
   output logic signed [EST_W-1:0] rsp_current_est,
   output logic                    rsp_lockout,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   macl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   macl_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_adc_code    (req_adc_code),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_ready_res   (rsp_ready_res),
      .rsp_average_mv  (rsp_average_mv),
      .rsp_report      (rsp_report),
      .rsp_current_est (rsp_current_est),
      .rsp_lockout     (rsp_lockout)
   );

endmodule

/* src/macl_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module macl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 50
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/macl_ctrl.sv */
// Sequencing controller: steps one transaction through the datapath and owns the result valid.
module macl_ctrl
   import macl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_ACC;
         ST_ACC:   state_in = status.window_full ? ST_AVG : ST_OUT;
         ST_AVG:   state_in = ST_CMP;
         ST_CMP:   state_in = ST_MAG;
         ST_MAG:   state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_SCALE: cmd.scale    = 1'b1;
         ST_ACC:   cmd.acc      = 1'b1;
         ST_AVG:   cmd.avg      = 1'b1;
         ST_CMP:   cmd.cmp      = 1'b1;
         ST_MAG:   cmd.mag      = 1'b1;
         ST_DIV:   cmd.div      = 1'b1;
         ST_OUT:   cmd.load_out = out_free;
         default:  cmd          = '0;
      endcase
   end

   // Hold the result until taken; a new one may replace it in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* src/macl_dp.sv */
// Datapath: scaling, sample ring with running sum, averaging, estimate and lockout hysteresis.
module macl_dp
   import macl_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic [CODE_W-1:0]            req_adc_code,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   output logic                         rsp_ready_res,
   output logic [MV_W-1:0]              rsp_average_mv,
   output logic                         rsp_report,
   output logic signed [EST_W-1:0]      rsp_current_est,
   output logic                         rsp_lockout
);

   // Configuration
   logic [THR_W-1:0]        thr_ff;
   logic signed [EST_W-1:0] lock_on_ff;
   logic signed [EST_W-1:0] lock_off_ff;

   // Window state
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic              full_ff, full_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [MV_W-1:0]   last_ff;
   logic              lock_ff, lock_in;

   // Per-transaction work registers
   logic [CODE_W-1:0]  code_ff;
   logic [SCALE_W-1:0] scaled_ff;
   logic               ready_ff;
   logic [MV_W-1:0]    avg_ff;
   logic               rep_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  mag_ff;
   logic               neg_ff;
   logic [QUOT_W-1:0]  quot_ff;

   // Result registers
   logic                    ready_out_ff;
   logic [MV_W-1:0]         avg_out_ff;
   logic                    rep_out_ff;
   logic signed [EST_W-1:0] est_out_ff;
   logic                    lock_out_ff;

   // Combinational helpers
   logic [MV_W-1:0]         old_mv;
   logic [CODE_W-1:0]       code_q0;
   logic [CODE_W:0]         code_rem;
   logic [CODE_W-1:0]       code_quot;
   logic [MV_W-1:0]         mv;
   logic [AVG_PROD_W-1:0]   avg_prod;
   logic [MV_W-1:0]         avg_diff;
   logic [DIV_PROD_W-1:0]   div_prod;
   logic signed [EST_W-1:0] est_mag;
   logic signed [EST_W-1:0] est;

   macl_ram #(
      .WIDTH (MV_W),
      .DEPTH (WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.acc),
      .wr_addr (slot_ff),
      .wr_data (mv),
      .rd_en   (cmd.capture),
      .rd_addr (slot_ff),
      .rd_data (old_mv)
   );

   // Divide by 4095 as x = q0*4096 + lo = q0*4095 + (q0 + lo); one correction step
   assign code_q0   = scaled_ff[SCALE_W-1 -: CODE_W];
   assign code_rem  = {1'b0, scaled_ff[CODE_W-1:0]} + {1'b0, code_q0};
   assign code_quot = code_q0 + CODE_W'(code_rem >= (CODE_W+1)'(CODE_MAX));
   assign mv        = MV_W'(MV_TOP) - code_quot;

   always_comb begin
      sum_in  = sum_ff;
      slot_in = slot_ff;
      full_in = full_ff;
      if (cmd.acc) begin
         sum_in = full_ff ? sum_ff - SUM_W'(old_mv) + SUM_W'(mv) : sum_ff + SUM_W'(mv);
         if (slot_ff == ADDR_W'(WINDOW_LEN - 1)) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_ff + 1'b1;
         end
      end
   end

   assign avg_prod = AVG_PROD_W'(sum_ff) * AVG_PROD_W'(AVG_MULT);
   assign avg_diff = (avg_ff > last_ff) ? avg_ff - last_ff : last_ff - avg_ff;
   assign div_prod = DIV_PROD_W'(mag_ff[PROD_W-1:DIV_PRE]) * DIV_PROD_W'(DIV_MULT);

   assign est_mag = {1'b0, quot_ff};
   assign est     = neg_ff ? -est_mag : est_mag;

   always_comb begin
      lock_in = lock_ff;
      if (rep_ff) begin
         if (est > lock_on_ff) begin
            lock_in = 1'b1;
         end else if (est < lock_off_ff) begin
            lock_in = 1'b0;
         end
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RST;
         lock_on_ff  <= LOCK_ON_RST;
         lock_off_ff <= LOCK_OFF_RST;
         slot_ff     <= '0;
         full_ff     <= 1'b0;
         sum_ff      <= '0;
         last_ff     <= '0;
         lock_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff      <= csr_wdata[THR_W-1:0];
               CSR_LOCK_ON:   lock_on_ff  <= $signed(csr_wdata[EST_W-1:0]);
               CSR_LOCK_OFF:  lock_off_ff <= $signed(csr_wdata[EST_W-1:0]);
               default:       ;
            endcase
         end
         slot_ff <= slot_in;
         full_ff <= full_in;
         sum_ff  <= sum_in;
         if (cmd.cmp && avg_diff > thr_ff) begin
            last_ff <= avg_ff;
         end
         if (cmd.load_out) begin
            lock_ff <= lock_in;
         end
      end
   end

   // Work and result registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         code_ff <= req_adc_code;
      end
      if (cmd.scale) begin
         scaled_ff <= {{(SCALE_W-CODE_W){1'b0}}, ~code_ff} * SCALE_W'(MV_SPAN);
      end
      if (cmd.acc) begin
         ready_ff <= full_ff;
         rep_ff   <= 1'b0;
         avg_ff   <= '0;
      end
      if (cmd.avg) begin
         avg_ff <= avg_prod[AVG_SHIFT +: MV_W];
      end
      if (cmd.cmp) begin
         rep_ff  <= avg_diff > thr_ff;
         prod_ff <= PROD_W'(avg_ff) * PROD_W'(EST_SLOPE);
      end
      if (cmd.mag) begin
         neg_ff <= prod_ff > PROD_W'(EST_BASE);
         mag_ff <= (prod_ff > PROD_W'(EST_BASE)) ? prod_ff - PROD_W'(EST_BASE)
                                                  : PROD_W'(EST_BASE) - prod_ff;
      end
      if (cmd.div) begin
         quot_ff <= div_prod[DIV_SHIFT +: QUOT_W];
      end
      if (cmd.load_out) begin
         ready_out_ff <= ready_ff;
         avg_out_ff   <= ready_ff ? avg_ff : '0;
         rep_out_ff   <= ready_ff && rep_ff;
         est_out_ff   <= (ready_ff && rep_ff) ? est : '0;
         lock_out_ff  <= lock_in;
      end
   end

   assign status.window_full = full_ff;

   assign rsp_ready_res   = ready_out_ff;
   assign rsp_average_mv  = avg_out_ff;
   assign rsp_report      = rep_out_ff;
   assign rsp_current_est = est_out_ff;
   assign rsp_lockout     = lock_out_ff;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the moving average change lockout unit.
module tb_top;
   import macl_pkg::*;

   localparam int NUM_PHASES     = 12;
   localparam int PHASE_SAMPLES  = 90;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_CAP      = 40;

   // Index 3 decodes to no register and must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic                    ready_res;
      logic [MV_W-1:0]         average_mv;
      logic                    report;
      logic signed [EST_W-1:0] current_est;
      logic                    lockout;
   } avg_result_type;

   typedef struct {
      logic [CODE_W-1:0] code;
      int                count;
      bit                typed;
      avg_result_type    want;
   } stim_row_type;

   localparam avg_result_type NO_CHECK      = '0;
   localparam avg_result_type FILL_OUT      = '0;
   localparam avg_result_type TOP_REPORT    = {1'b1, 12'd3300, 1'b1, -15'sd690, 1'b0};
   localparam avg_result_type TOP_HOLD      = {1'b1, 12'd3300, 1'b0, 15'sd0, 1'b0};
   localparam avg_result_type BOTTOM_REPORT = {1'b1, 12'd280, 1'b1, 15'sd8909, 1'b1};
   localparam avg_result_type BOTTOM_HOLD   = {1'b1, 12'd280, 1'b0, 15'sd0, 1'b1};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [CODE_W-1:0]       req_adc_code = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_ready_res;
   logic [MV_W-1:0]         rsp_average_mv;
   logic                    rsp_report;
   logic signed [EST_W-1:0] rsp_current_est;
   logic                    rsp_lockout;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Mirror of the block state and registers
   int unsigned win_ring [WINDOW_LEN];
   int unsigned win_slot   = 0;
   bit          win_full   = 1'b0;
   int unsigned win_sum    = 0;
   int unsigned last_avg   = 0;
   bit          lock_state = 1'b0;
   int unsigned cfg_thr    = THRESHOLD_RST;
   int          cfg_on     = LOCK_ON_RST;
   int          cfg_off    = LOCK_OFF_RST;

   avg_result_type pending_readings [$];
   stim_row_type   plan [11];

   int mismatches   = 0;
   int n_samples    = 0;
   int n_reports    = 0;
   int n_lock_flips = 0;
   int n_csr_writes = 0;
   int snd_pct      = 0;
   int rcv_pct      = 0;
   int idle_cycles  = 0;

   moving_average_change_lockout_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_adc_code    (req_adc_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ready_res   (rsp_ready_res),
      .rsp_average_mv  (rsp_average_mv),
      .rsp_report      (rsp_report),
      .rsp_current_est (rsp_current_est),
      .rsp_lockout     (rsp_lockout),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   task automatic flag_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Scale one code, slide the window and update report and lockout state
   function automatic avg_result_type advance_window(input logic [CODE_W-1:0] code);
      int unsigned    mv;
      int unsigned    avg;
      int unsigned    gap;
      int             est;
      avg_result_type r;
      r  = '0;
      mv = MV_TOP - ((CODE_MAX - int'(code)) * MV_SPAN) / CODE_MAX;
      if (win_full) begin
         win_sum = win_sum - win_ring[win_slot] + mv;
         win_ring[win_slot] = mv;
         win_slot = (win_slot == WINDOW_LEN - 1) ? 0 : win_slot + 1;
         avg = win_sum / WINDOW_LEN;
         gap = (avg > last_avg) ? avg - last_avg : last_avg - avg;
         r.ready_res  = 1'b1;
         r.average_mv = avg[MV_W-1:0];
         if (gap > cfg_thr) begin
            est = (EST_BASE - EST_SLOPE * int'(avg)) / 1000;
            last_avg      = avg;
            r.report      = 1'b1;
            r.current_est = est[EST_W-1:0];
            n_reports++;
            if (est > cfg_on) begin
               if (!lock_state) n_lock_flips++;
               lock_state = 1'b1;
            end else if (est < cfg_off) begin
               if (lock_state) n_lock_flips++;
               lock_state = 1'b0;
            end
         end
      end else begin
         win_sum += mv;
         win_ring[win_slot] = mv;
         if (win_slot == WINDOW_LEN - 1) begin
            win_slot = 0;
            win_full = 1'b1;
         end else begin
            win_slot = win_slot + 1;
         end
      end
      r.lockout = lock_state;
      return r;
   endfunction

   // Leaves csr_we high; the caller drops it after the last write of a batch
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      n_csr_writes++;
      case (idx)
         CSR_THRESHOLD: cfg_thr = data[THR_W-1:0];
         CSR_LOCK_ON:   cfg_on  = int'($signed(data));
         CSR_LOCK_OFF:  cfg_off = int'($signed(data));
         default: ;
      endcase
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_level();
      int v;
      case ($urandom_range(5))
         0: v = -1000;
         1: v = 10000;
         2: v = -16384;
         3: v = 16383;
         4: v = int'($urandom_range(11000)) - 1000;
         default: v = int'($urandom_range(32767));
      endcase
      return v[CSR_DATA_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_threshold();
      logic [CSR_DATA_W-1:0] d;
      d = CSR_DATA_W'($urandom_range(32767));
      case ($urandom_range(3))
         0: d[THR_W-1:0] = '0;
         1: d[THR_W-1:0] = '1;
         2: d[THR_W-1:0] = THR_W'($urandom_range(40));
         default: ;
      endcase
      return d;
   endfunction

   task automatic send_code(input logic [CODE_W-1:0] code, input bit typed,
                            input avg_result_type want);
      avg_result_type calc;
      while ($urandom_range(99) < snd_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_adc_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      calc = advance_window(code);
      pending_readings.push_back(typed ? want : calc);
      n_samples++;
   endtask

   // Hold the sender until every outstanding transaction has come back
   task automatic drain_readings();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else       rsp_stall <= ($urandom_range(99) < rcv_pct);
   end

   always @(posedge clock) begin
      avg_result_type seen;
      avg_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_ready_res, rsp_average_mv, rsp_report, rsp_current_est, rsp_lockout};
         if (pending_readings.size() == 0) begin
            flag_mismatch("result with no sample outstanding");
         end else begin
            want = pending_readings.pop_front();
            if (seen.ready_res !== want.ready_res)
               flag_mismatch($sformatf("ready_res got %b want %b",
                                       seen.ready_res, want.ready_res));
            if (seen.average_mv !== want.average_mv)
               flag_mismatch($sformatf("average_mv got %0d want %0d",
                                       seen.average_mv, want.average_mv));
            if (seen.report !== want.report)
               flag_mismatch($sformatf("report got %b want %b", seen.report, want.report));
            if (seen.current_est !== want.current_est)
               flag_mismatch($sformatf("current_est got %0d want %0d",
                                       seen.current_est, want.current_est));
            if (seen.lockout !== want.lockout)
               flag_mismatch($sformatf("lockout got %b want %b", seen.lockout, want.lockout));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_readings.size());
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : main
      int phase;
      int sent;
      int run_len;
      int level;
      int spread;
      int c;
      int k;
      bit noisy;

      foreach (win_ring[i]) win_ring[i] = 0;

      plan = '{
         '{12'hFFF, 50, 1'b1, FILL_OUT},       // fill the window, last one is the filling sample
         '{12'hFFF,  1, 1'b1, TOP_REPORT},     // first average, far from zero
         '{12'hFFF,  1, 1'b1, TOP_HOLD},       // no movement, no report
         '{12'h000, 49, 1'b0, NO_CHECK},       // ramp down, lockout sets on the way
         '{12'h000,  1, 1'b1, BOTTOM_REPORT},
         '{12'h000,  1, 1'b1, BOTTOM_HOLD},
         '{12'hAAA,  1, 1'b0, NO_CHECK},
         '{12'h555,  1, 1'b0, NO_CHECK},
         '{12'h001,  1, 1'b0, NO_CHECK},
         '{12'hFFE,  1, 1'b0, NO_CHECK},
         '{12'h800, 20, 1'b0, NO_CHECK}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i])
         for (k = 0; k < plan[i].count; k++)
            send_code(plan[i].code, plan[i].typed, plan[i].want);

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_readings();
         snd_pct = 0;
         rcv_pct = 0;
         if (phase == 0) begin
            // report on any movement, lockout frozen
            write_csr(CSR_THRESHOLD, {3'b111, 12'd0});
            write_csr(CSR_LOCK_ON, 15'sd10000);
            write_csr(CSR_LOCK_OFF, -15'sd1000);
            write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(32767)));
         end else if (phase == 1) begin
            // never reports
            write_csr(CSR_THRESHOLD, {3'b000, 12'd4095});
            write_csr(CSR_LOCK_ON, -15'sd1000);
            write_csr(CSR_LOCK_OFF, 15'sd10000);
         end else begin
            if ($urandom_range(3) != 0) write_csr(CSR_THRESHOLD, pick_threshold());
            if ($urandom_range(3) != 0) write_csr(CSR_LOCK_ON, pick_level());
            if ($urandom_range(3) != 0) write_csr(CSR_LOCK_OFF, pick_level());
            if ($urandom_range(1) != 0)
               write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(32767)));
         end
         csr_we <= 1'b0;

         case (phase % 4)
            1: snd_pct = 74;
            2: rcv_pct = 74;
            3: begin
               snd_pct = 38;
               rcv_pct = 38;
            end
            default: ;
         endcase

         sent = 0;
         while (sent < PHASE_SAMPLES) begin
            // Mostly runs around one level so the average swings far; some pure noise
            run_len = $urandom_range(90, 10);
            noisy   = ($urandom_range(9) < 3);
            case ($urandom_range(3))
               0: level = 0;
               1: level = 4095;
               default: level = $urandom_range(4095);
            endcase
            spread = $urandom_range(300);
            for (k = 0; k < run_len && sent < PHASE_SAMPLES; k++) begin
               if ($urandom_range(199) == 0) drain_readings();
               if (noisy) begin
                  c = $urandom_range(4095);
               end else begin
                  c = level + int'($urandom_range(2 * spread)) - spread;
                  if (c < 0)    c = 0;
                  if (c > 4095) c = 4095;
               end
               send_code(c[CODE_W-1:0], 1'b0, NO_CHECK);
               sent++;
            end
         end
      end

      drain_readings();
      if (pending_readings.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_readings.size()));

      $display("Run covered %0d samples over %0d register settings and %0d register writes,",
               n_samples, NUM_PHASES + 1, n_csr_writes);
      $display("with %0d reports and %0d lockout changes; %0d mismatches.",
               n_reports, n_lock_flips, mismatches);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
src/macl_pkg.sv
src/macl_ram.sv
src/macl_ctrl.sv
src/macl_dp.sv
src/moving_average_change_lockout_unit.sv
tb/tb_top.sv
